// ----- src/dau_pkg.sv -----
// Shared constants and helper functions for the decimal ASCII to unsigned parser.
`default_nettype none

package dau_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Width mode register codes; the unused code behaves as 32 bit.
  localparam logic [1:0] WM_8BIT  = 2'd0;
  localparam logic [1:0] WM_16BIT = 2'd1;
  localparam logic [1:0] WM_32BIT = 2'd2;

  localparam logic [7:0] ASCII_ZERO      = 8'd48;
  localparam logic [7:0] ASCII_PAST_NINE = 8'd58;

  localparam int unsigned WEIGHT_W  = 34;  // holds 10^10
  localparam int unsigned PART_W    = 38;  // holds 9 * 10^10 plus a 32 bit sum
  localparam int unsigned VALUE_W   = 32;
  localparam logic [3:0]  EXP_CAP   = 4'd10;

  localparam logic [VALUE_W-1:0] MAX_8  = 32'd255;
  localparam logic [VALUE_W-1:0] MAX_16 = 32'd65535;
  localparam logic [VALUE_W-1:0] MAX_32 = 32'd4294967295;

  // Power of ten for a digit position, position 0 being the units.
  function automatic logic [WEIGHT_W-1:0] pow10(input logic [3:0] exp_idx);
    logic [WEIGHT_W-1:0] w;
    case (exp_idx)
      4'd0:    w = 34'd1;
      4'd1:    w = 34'd10;
      4'd2:    w = 34'd100;
      4'd3:    w = 34'd1000;
      4'd4:    w = 34'd10000;
      4'd5:    w = 34'd100000;
      4'd6:    w = 34'd1000000;
      4'd7:    w = 34'd10000000;
      4'd8:    w = 34'd100000000;
      4'd9:    w = 34'd1000000000;
      default: w = 34'd10000000000;
    endcase
    return w;
  endfunction

  // Largest value allowed for a width mode.
  function automatic logic [VALUE_W-1:0] width_limit(input logic [1:0] mode);
    logic [VALUE_W-1:0] lim;
    case (mode)
      WM_8BIT:  lim = MAX_8;
      WM_16BIT: lim = MAX_16;
      default:  lim = MAX_32;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

// ----- src/decimal_ascii_to_unsigned_unit.sv -----
// Decimal ASCII to unsigned integer parser, characters fed from last to first.
// A string's result is formed as its final character moves from the input register into
// the result register, where it is held until taken. Throughput: one character per cycle,
// except while a final character waits on an untaken result; the parse state update is a
// 4 x 34 bit multiply by the digit plus one 38 bit add and compare, all combinational.
// Synchronous active-low reset empties both registers, clears the parse state, sets 32 bit.
`default_nettype none

module decimal_ascii_to_unsigned_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: width mode register.
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  // Character requests.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_is_final,
  // Result requests.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_value,
  output logic [1:0]       out_status
);

  // Width mode register.
  logic [1:0] width_mode_r;

  // Input register stage.
  logic       s1_vld_r;
  logic [7:0] s1_char_r;
  logic       s1_final_r;

  // Parse state. The place weight is kept as a power of ten exponent, which
  // saturates at ten just like the weight itself saturates at 10^10. Only the
  // fact that a digit was seen matters, so one flag stands for the count.
  logic [dau_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic [3:0]                  exp_r, exp_nxt;
  logic                        seen_r, seen_nxt;
  logic [1:0]                  err_r, err_nxt;

  // Result register.
  logic                        out_vld_r;
  logic [dau_pkg::VALUE_W-1:0] out_value_r;
  logic [1:0]                  out_status_r;

  logic                        advance;
  logic                        in_accept;
  logic                        is_digit;
  logic [3:0]                  digit;
  logic [dau_pkg::PART_W-1:0]  part;
  logic [dau_pkg::PART_W-1:0]  sum;
  logic [dau_pkg::VALUE_W-1:0] limit;

  // The character held in the input register moves on unless it is a final
  // character and the result register still holds an untaken result.
  assign advance   = s1_vld_r && (!s1_final_r || !out_vld_r || !out_stall);
  assign in_stall  = s1_vld_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r <= dau_pkg::WM_32BIT;
    end else if (cfg_wr_en) begin
      width_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_accept) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_char_r  <= in_char_code;
      s1_final_r <= in_is_final;
    end
  end

  // One character of parse work. A digit is added at the current weight
  // unless the sum would pass the limit of the width in force; zero digits
  // beyond the width's digit count add nothing and are therefore accepted.
  always_comb begin
    is_digit = (s1_char_r >= dau_pkg::ASCII_ZERO) && (s1_char_r < dau_pkg::ASCII_PAST_NINE);
    digit    = 4'(s1_char_r - dau_pkg::ASCII_ZERO);
    limit    = dau_pkg::width_limit(width_mode_r);
    part     = dau_pkg::PART_W'(digit) * dau_pkg::PART_W'(dau_pkg::pow10(exp_r));
    sum      = dau_pkg::PART_W'(acc_r) + part;

    acc_nxt  = acc_r;
    exp_nxt  = exp_r;
    seen_nxt = seen_r;
    err_nxt  = err_r;

    // Once an error is recorded the rest of the string changes nothing.
    if (err_r == dau_pkg::ST_OK) begin
      if (!is_digit) begin
        if (seen_r) begin
          err_nxt = dau_pkg::ST_INVALID;
        end
      end else if (sum > dau_pkg::PART_W'(limit)) begin
        err_nxt = dau_pkg::ST_OVERFLOW;
      end else begin
        acc_nxt  = sum[dau_pkg::VALUE_W-1:0];
        seen_nxt = 1'b1;
        if (exp_r < dau_pkg::EXP_CAP) begin
          exp_nxt = exp_r + 4'd1;
        end
      end
    end
  end

  // The parse state goes back to its start values after each final character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      exp_r  <= '0;
      seen_r <= 1'b0;
      err_r  <= dau_pkg::ST_OK;
    end else if (advance) begin
      if (s1_final_r) begin
        acc_r  <= '0;
        exp_r  <= '0;
        seen_r <= 1'b0;
        err_r  <= dau_pkg::ST_OK;
      end else begin
        acc_r  <= acc_nxt;
        exp_r  <= exp_nxt;
        seen_r <= seen_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && s1_final_r) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  // The value is reported only for a clean parse; any error reports zero.
  always_ff @(posedge clk) begin
    if (advance && s1_final_r) begin
      out_status_r <= err_nxt;
      out_value_r  <= (err_nxt == dau_pkg::ST_OK) ? acc_nxt : '0;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire
